[hdl/ppcsa_pkg.sv]
// ----------------------------------------------------------------------------
// ppcsa_pkg
// Shared types, constants and helpers for the packet protocol counter.
// ----------------------------------------------------------------------------
package ppcsa_pkg;

	localparam int COUNT_WIDTH     = 32;
	localparam int MAX_FRAME_BYTES = 65536;

	localparam int CNT_W     = COUNT_WIDTH;
	localparam int POS_W     = 16;
	localparam int OUT_W     = 32;
	localparam int PORT_W    = 16;
	localparam int THR_W     = 32;
	localparam int CFG_W     = 32;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
	localparam int NUM_CNT   = 5;

	localparam logic [POS_W-1:0] POS_MAX       = '1;
	localparam logic [POS_W:0]   POS_LIMIT     = (POS_W + 1)'(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_ETYPE_HI  = 16'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO  = 16'd13;
	localparam logic [POS_W-1:0] POS_IHL       = 16'd14;
	localparam logic [POS_W-1:0] POS_PROTO     = 16'd23;
	localparam logic [6:0]       IP_BASE       = 7'd14;
	localparam logic [POS_W-1:0] OFF_PORT_HI   = 16'd2;
	localparam logic [POS_W-1:0] OFF_PORT_LO   = 16'd3;
	localparam logic [POS_W-1:0] OFF_FLAGS     = 16'd13;

	localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  IHL_MASK    = 8'h0f;
	localparam logic [7:0]  FLAGS_SYN   = 8'h02;
	localparam logic [7:0]  PROTO_TCP   = 8'd6;
	localparam logic [7:0]  PROTO_UDP   = 8'd17;
	localparam logic [THR_W-1:0] SYN_THRESHOLD_RESET = 32'd1500;

	typedef enum logic {
		REG_WATCHED_PORT  = 1'b0,
		REG_SYN_THRESHOLD = 1'b1
	} reg_index_t;

	typedef enum logic {
		CMD_BYTE   = 1'b0,
		CMD_REPORT = 1'b1
	} cmd_t;

	typedef enum logic {
		RES_REPORT = 1'b0,
		RES_ALERT  = 1'b1
	} result_kind_t;

	typedef enum logic {
		EV_FRAME  = 1'b0,
		EV_REPORT = 1'b1
	} ev_kind_t;

	typedef enum logic [2:0] {
		CNT_IPV4 = 3'd0,
		CNT_TCP  = 3'd1,
		CNT_UDP  = 3'd2,
		CNT_SYN  = 3'd3,
		CNT_ALL  = 3'd4
	} cnt_sel_t;

	typedef struct packed {
		ev_kind_t kind;
		logic     is_ipv4;
		logic     is_tcp;
		logic     is_udp;
		logic     syn_flags;
		logic     port_match;
	} event_t;

	typedef logic [CNT_W-1:0] count_t;

	function automatic count_t sat_inc(input count_t c, input logic en);
		count_t r;
		r = c;
		if (en && (c != '1))
			r = c + count_t'(1);
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input count_t c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_W-1:0];
	endfunction

endpackage

[hdl/packet_protocol_counter_syn_alert.sv]
// ----------------------------------------------------------------------------
// packet_protocol_counter_syn_alert
// Ethernet/IPv4 protocol counter with a one-time TCP SYN flood alert.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_ready     cmd, frame_byte, frame_last
//  out      out_valid / out_ready   result_kind, five 32-bit counters
//  config   wr_en (no wait)         wr_index, wr_data
//
//  One beat per cycle while the event queue is not full; a report, or a
//  frame end that raises the alert, goes through the parser, a queue of four
//  events and the counter stage into the result register.
//  A stalled result holds the counter stage at the next report or alert; the
//  parser keeps taking beats until the event queue is full.
//  Reset clears counters, alert latch, parser state and sets the threshold
//  to 1500.
// ----------------------------------------------------------------------------
module packet_protocol_counter_syn_alert (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [7:0]                       frame_byte,
	input  logic                             frame_last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             result_kind,
	output logic [ppcsa_pkg::OUT_W-1:0]      ipv4_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      tcp_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      udp_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      syn_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      all_frames,
	input  logic                             wr_en,
	input  logic                             wr_index,
	input  logic [ppcsa_pkg::CFG_W-1:0]      wr_data
);

	logic [ppcsa_pkg::PORT_W-1:0] watched_port_q;
	logic [ppcsa_pkg::THR_W-1:0]  syn_threshold_q;
	logic                         q_full;
	logic                         push;
	ppcsa_pkg::event_t            push_ev;
	logic                         ev_valid;
	ppcsa_pkg::event_t            ev;
	logic                         pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_port_q  <= '0;
			syn_threshold_q <= ppcsa_pkg::SYN_THRESHOLD_RESET;
		end else if (wr_en) begin
			case (ppcsa_pkg::reg_index_t'(wr_index))
				ppcsa_pkg::REG_WATCHED_PORT:  watched_port_q  <= wr_data[ppcsa_pkg::PORT_W-1:0];
				ppcsa_pkg::REG_SYN_THRESHOLD: syn_threshold_q <= wr_data[ppcsa_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	ppcsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.frame_byte   (frame_byte),
		.frame_last   (frame_last),
		.watched_port (watched_port_q),
		.q_full       (q_full),
		.push         (push),
		.push_ev      (push_ev)
	);

	ppcsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ev  (push_ev),
		.full     (q_full),
		.ev_valid (ev_valid),
		.ev       (ev),
		.pop      (pop)
	);

	ppcsa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev_valid      (ev_valid),
		.ev            (ev),
		.pop           (pop),
		.syn_threshold (syn_threshold_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.ipv4_frames   (ipv4_frames),
		.tcp_frames    (tcp_frames),
		.udp_frames    (udp_frames),
		.syn_frames    (syn_frames),
		.all_frames    (all_frames)
	);

endmodule

[hdl/ppcsa_front.sv]
// ----------------------------------------------------------------------------
// ppcsa_front
// Byte parser: captures header fields, classifies each frame at its end and passes report commands on.
// ----------------------------------------------------------------------------
module ppcsa_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [7:0]                        frame_byte,
	input  logic                              frame_last,
	input  logic [ppcsa_pkg::PORT_W-1:0]      watched_port,
	input  logic                              q_full,
	output logic                              push,
	output ppcsa_pkg::event_t                 push_ev
);

	logic [ppcsa_pkg::POS_W-1:0] pos_q, pos_n;
	logic [15:0]                 etype_q, etype_n;
	logic [3:0]                  ihl_q, ihl_n;
	logic [7:0]                  proto_q, proto_n;
	logic [15:0]                 port_q, port_n;
	logic [7:0]                  flags_q, flags_n;
	logic [4:0]                  seen_q, seen_n;
	logic [6:0]                  base;
	logic [ppcsa_pkg::POS_W-1:0] base_w;
	logic [7:0]                  ihl_byte;
	logic                        beat;
	logic                        is_byte;
	logic                        cap;
	logic                        ipv4, tcp;

	assign in_ready = !q_full;
	assign beat     = in_valid && in_ready;
	assign is_byte  = (ppcsa_pkg::cmd_t'(cmd) == ppcsa_pkg::CMD_BYTE);
	assign cap      = ({1'b0, pos_q} < ppcsa_pkg::POS_LIMIT);
	assign base     = ppcsa_pkg::IP_BASE + {1'b0, ihl_q, 2'b00};
	assign base_w   = ppcsa_pkg::POS_W'(base);
	assign ihl_byte = frame_byte & ppcsa_pkg::IHL_MASK;
	assign pos_n    = (pos_q != ppcsa_pkg::POS_MAX) ?
		pos_q + ppcsa_pkg::POS_W'(1) : pos_q;

	always_comb begin
		etype_n = etype_q;
		ihl_n   = ihl_q;
		proto_n = proto_q;
		port_n  = port_q;
		flags_n = flags_q;
		seen_n  = seen_q;
		if (cap) begin
			if (pos_q == ppcsa_pkg::POS_ETYPE_HI) begin
				etype_n = {frame_byte, 8'h00};
			end else if (pos_q == ppcsa_pkg::POS_ETYPE_LO) begin
				etype_n   = {etype_q[15:8], frame_byte};
				seen_n[0] = 1'b1;
			end else if (pos_q == ppcsa_pkg::POS_IHL) begin
				ihl_n     = ihl_byte[3:0];
				seen_n[1] = 1'b1;
			end else if (pos_q == ppcsa_pkg::POS_PROTO) begin
				proto_n   = frame_byte;
				seen_n[2] = 1'b1;
			end
			if (seen_q[1]) begin
				if (pos_q == base_w + ppcsa_pkg::OFF_PORT_HI) begin
					port_n = {frame_byte, 8'h00};
				end else if (pos_q == base_w + ppcsa_pkg::OFF_PORT_LO) begin
					port_n    = {port_q[15:8], frame_byte};
					seen_n[3] = 1'b1;
				end else if (pos_q == base_w + ppcsa_pkg::OFF_FLAGS) begin
					flags_n   = frame_byte;
					seen_n[4] = 1'b1;
				end
			end
		end
	end

	assign ipv4 = seen_n[0] && (etype_n == ppcsa_pkg::ETYPE_IPV4);
	assign tcp  = ipv4 && seen_n[2] && (proto_n == ppcsa_pkg::PROTO_TCP);

	always_comb begin
		push_ev.kind       = is_byte ? ppcsa_pkg::EV_FRAME : ppcsa_pkg::EV_REPORT;
		push_ev.is_ipv4    = ipv4;
		push_ev.is_tcp     = tcp;
		push_ev.is_udp     = ipv4 && seen_n[2] && (proto_n == ppcsa_pkg::PROTO_UDP);
		push_ev.syn_flags  = tcp && seen_n[4] && (flags_n == ppcsa_pkg::FLAGS_SYN);
		push_ev.port_match = seen_n[3] && (port_n == watched_port);
	end

	assign push = beat && (!is_byte || frame_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			ihl_q   <= '0;
			proto_q <= '0;
			port_q  <= '0;
			flags_q <= '0;
			seen_q  <= '0;
		end else if (beat && is_byte) begin
			if (frame_last) begin
				pos_q   <= '0;
				etype_q <= '0;
				ihl_q   <= '0;
				proto_q <= '0;
				port_q  <= '0;
				flags_q <= '0;
				seen_q  <= '0;
			end else begin
				pos_q   <= pos_n;
				etype_q <= etype_n;
				ihl_q   <= ihl_n;
				proto_q <= proto_n;
				port_q  <= port_n;
				flags_q <= flags_n;
				seen_q  <= seen_n;
			end
		end
	end

endmodule

[hdl/ppcsa_queue.sv]
// ----------------------------------------------------------------------------
// ppcsa_queue
// Short event queue between the parser and the counter stage.
// ----------------------------------------------------------------------------
module ppcsa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ppcsa_pkg::event_t  push_ev,
	output logic               full,
	output logic               ev_valid,
	output ppcsa_pkg::event_t  ev,
	input  logic               pop
);

	ppcsa_pkg::event_t                 slot_q [ppcsa_pkg::Q_DEPTH];
	logic [ppcsa_pkg::Q_PTR_W-1:0]     wr_q, rd_q;
	logic [ppcsa_pkg::Q_CNT_W-1:0]     cnt_q;
	logic                              do_pop;

	assign full     = (cnt_q == ppcsa_pkg::Q_CNT_W'(ppcsa_pkg::Q_DEPTH));
	assign ev_valid = (cnt_q != '0);
	assign ev       = slot_q[rd_q];
	assign do_pop   = pop && ev_valid;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + ppcsa_pkg::Q_PTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + ppcsa_pkg::Q_PTR_W'(1);
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + ppcsa_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - ppcsa_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ppcsa_pkg::Q_CNT_W'(ppcsa_pkg::Q_DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !ev_valid) |=> $stable(rd_q))
		else $error("read pointer moved on empty queue");

endmodule

[hdl/ppcsa_back.sv]
// ----------------------------------------------------------------------------
// ppcsa_back
// Counter stage: saturating counters, SYN alert latch and result register.
// ----------------------------------------------------------------------------
module ppcsa_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ev_valid,
	input  ppcsa_pkg::event_t                ev,
	output logic                             pop,
	input  logic [ppcsa_pkg::THR_W-1:0]      syn_threshold,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             result_kind,
	output logic [ppcsa_pkg::OUT_W-1:0]      ipv4_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      tcp_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      udp_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      syn_frames,
	output logic [ppcsa_pkg::OUT_W-1:0]      all_frames
);

	ppcsa_pkg::count_t              cnt_q [ppcsa_pkg::NUM_CNT];
	ppcsa_pkg::count_t              cnt_n [ppcsa_pkg::NUM_CNT];
	logic                           alert_latch_q;
	logic                           out_valid_q;
	ppcsa_pkg::result_kind_t        kind_q;
	logic [ppcsa_pkg::OUT_W-1:0]    res_q [ppcsa_pkg::NUM_CNT];
	logic                           is_report;
	logic                           alert;
	logic                           produce;
	logic                           slot_free;
	logic                           load;

	assign is_report = (ev.kind == ppcsa_pkg::EV_REPORT);

	always_comb begin
		cnt_n[ppcsa_pkg::CNT_ALL]  = ppcsa_pkg::sat_inc(cnt_q[ppcsa_pkg::CNT_ALL], 1'b1);
		cnt_n[ppcsa_pkg::CNT_IPV4] = ppcsa_pkg::sat_inc(cnt_q[ppcsa_pkg::CNT_IPV4], ev.is_ipv4);
		cnt_n[ppcsa_pkg::CNT_TCP]  = ppcsa_pkg::sat_inc(cnt_q[ppcsa_pkg::CNT_TCP], ev.is_tcp);
		cnt_n[ppcsa_pkg::CNT_UDP]  = ppcsa_pkg::sat_inc(cnt_q[ppcsa_pkg::CNT_UDP], ev.is_udp);
		cnt_n[ppcsa_pkg::CNT_SYN]  = ppcsa_pkg::sat_inc(cnt_q[ppcsa_pkg::CNT_SYN],
			ev.syn_flags && ev.port_match);
	end

	assign alert = !is_report && ev.syn_flags && !alert_latch_q &&
		(64'(cnt_n[ppcsa_pkg::CNT_SYN]) >= 64'(syn_threshold));
	assign produce   = is_report || alert;
	assign slot_free = !out_valid_q || out_ready;
	assign pop       = ev_valid && (!produce || slot_free);
	assign load      = pop && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppcsa_pkg::NUM_CNT; i++)
				cnt_q[i] <= '0;
			alert_latch_q <= 1'b0;
		end else if (pop) begin
			if (is_report) begin
				for (int i = 0; i < ppcsa_pkg::NUM_CNT; i++)
					cnt_q[i] <= '0;
				alert_latch_q <= 1'b0;
			end else begin
				for (int i = 0; i < ppcsa_pkg::NUM_CNT; i++)
					cnt_q[i] <= cnt_n[i];
				if (alert)
					alert_latch_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= is_report ? ppcsa_pkg::RES_REPORT : ppcsa_pkg::RES_ALERT;
			for (int i = 0; i < ppcsa_pkg::NUM_CNT; i++)
				res_q[i] <= ppcsa_pkg::sat_out(is_report ? cnt_q[i] : cnt_n[i]);
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign ipv4_frames = res_q[ppcsa_pkg::CNT_IPV4];
	assign tcp_frames  = res_q[ppcsa_pkg::CNT_TCP];
	assign udp_frames  = res_q[ppcsa_pkg::CNT_UDP];
	assign syn_frames  = res_q[ppcsa_pkg::CNT_SYN];
	assign all_frames  = res_q[ppcsa_pkg::CNT_ALL];

	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_report) |=> (cnt_q[ppcsa_pkg::CNT_ALL] == '0 &&
			cnt_q[ppcsa_pkg::CNT_SYN] == '0 && !alert_latch_q))
		else $error("report did not clear counters and latch");

	a_latch_by_alert: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(alert_latch_q) |-> (out_valid_q && kind_q == ppcsa_pkg::RES_ALERT))
		else $error("alert latch set without an alert result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !load)
		else $error("result register overwritten while stalled");

endmodule
